// File: rtl/sdi_pkg.sv
// Shared types and constants of the SD card start-up sequencer.
package sdi_pkg;

  // Elapsed-time counter width; compare width covers counter and timeout.
  localparam int ELAPSED_WIDTH = 16;
  localparam int TIMEOUT_WIDTH = 16;
  localparam int ELAPSED_CMP_W = (ELAPSED_WIDTH > TIMEOUT_WIDTH) ? ELAPSED_WIDTH : TIMEOUT_WIDTH;

  // Item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Completion status codes
  localparam logic [1:0] CST_OK      = 2'd0;
  localparam logic [1:0] CST_TIMEOUT = 2'd1;
  localparam logic [1:0] CST_CRC     = 2'd2;

  // Expected response kinds
  localparam logic [1:0] REPLY_NONE  = 2'd0;
  localparam logic [1:0] REPLY_SHORT = 2'd1;
  localparam logic [1:0] REPLY_LONG  = 2'd2;

  // Init status codes
  localparam logic [1:0] INIT_BUSY    = 2'd0;
  localparam logic [1:0] INIT_READY   = 2'd1;
  localparam logic [1:0] INIT_NO_CARD = 2'd2;
  localparam logic [1:0] INIT_FAILED  = 2'd3;

  // Card kinds
  localparam logic [1:0] CARD_UNKNOWN = 2'd0;
  localparam logic [1:0] CARD_MMC     = 2'd1;
  localparam logic [1:0] CARD_SD1     = 2'd2;
  localparam logic [1:0] CARD_SD2     = 2'd3;

  // Command indexes
  localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
  localparam logic [5:0] CMD_SEND_OP_COND = 6'd1;
  localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA     = 6'd3;
  localparam logic [5:0] CMD_SET_BUS_W    = 6'd6;
  localparam logic [5:0] CMD_SELECT       = 6'd7;
  localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
  localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
  localparam logic [5:0] CMD_SD_OP_COND   = 6'd41;
  localparam logic [5:0] CMD_APP          = 6'd55;

  // Arguments and response masks
  localparam logic [31:0] ARG_IF_COND      = 32'h0000_01AA;
  localparam logic [11:0] IF_COND_ECHO     = 12'h1AA;
  localparam logic [31:0] ARG_OP_COND_HCS  = 32'h40ff_8000;
  localparam logic [31:0] ARG_OP_COND      = 32'h00ff_8000;
  localparam logic [31:0] ARG_MMC_OP_COND  = 32'h00FF_8000;
  localparam logic [31:0] ARG_BLOCK_LEN    = 32'd512;
  localparam logic [31:0] ARG_BUS_4BIT     = 32'd2;
  localparam logic [31:0] ARG_MMC_RCA      = 32'h0001_0000;
  localparam logic [31:0] R1_APP_CMD       = 32'h0000_0020;
  localparam logic [31:0] R1_ERR_MASK      = 32'hfdf9_0000;
  localparam logic [15:0] MMC_RCA          = 16'd1;
  localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'd1000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        card_absent;
    logic [1:0]  cmd_status;
    logic [31:0] resp_word;
  } sdi_item_t;

  typedef struct packed {
    logic        issue;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  resp_kind;
    logic [1:0]  init_status;
    logic [1:0]  card_kind;
    logic        block_addressing;
    logic [15:0] card_address;
    logic        wide_bus;
  } sdi_result_t;

endpackage

// File: rtl/sdi_in_if.sv
// Input item channel of the SD card start-up sequencer.
interface sdi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        card_absent;
  logic [1:0]  cmd_status;
  logic [31:0] resp_word;

  modport source (output valid, cmd, card_absent, cmd_status, resp_word, input ready);
  modport sink   (input valid, cmd, card_absent, cmd_status, resp_word, output ready);
endinterface

// File: rtl/sdi_out_if.sv
// Result channel of the SD card start-up sequencer.
interface sdi_out_if;
  logic        valid;
  logic        ready;
  logic        issue;
  logic [5:0]  cmd_index;
  logic [31:0] cmd_arg;
  logic [1:0]  resp_kind;
  logic [1:0]  init_status;
  logic [1:0]  card_kind;
  logic        block_addressing;
  logic [15:0] card_address;
  logic        wide_bus;

  modport source (output valid, issue, cmd_index, cmd_arg, resp_kind, init_status, card_kind,
                  block_addressing, card_address, wide_bus, input ready);
  modport sink   (input valid, issue, cmd_index, cmd_arg, resp_kind, init_status, card_kind,
                  block_addressing, card_address, wide_bus, output ready);
endinterface

// File: rtl/sdi_cfg_if.sv
// Configuration write channel carrying the ready-poll timeout.
interface sdi_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/sdi_in_stage.sv
// Input register stage: captures one item per transfer for the step logic.
module sdi_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  sdi_in_if.sink             in_ch,
  input  logic               take,
  output logic               item_valid,
  output sdi_pkg::sdi_item_t item
);
  import sdi_pkg::*;

  logic      valid_r, valid_nxt;
  sdi_item_t item_r;
  logic      accept;

  // Accept when empty or when the held item moves on this cycle
  assign in_ch.ready = !valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cmd         <= in_ch.cmd;
      item_r.card_absent <= in_ch.card_absent;
      item_r.cmd_status  <= in_ch.cmd_status;
      item_r.resp_word   <= in_ch.resp_word;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule

// File: rtl/sdi_step.sv
// Init state machine: decides one item per cycle while the result is not stalled, and registers the result.
module sdi_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  sdi_pkg::sdi_item_t item,
  output logic               take,
  sdi_cfg_if.sink            cfg_ch,
  sdi_out_if.source          out_ch
);
  import sdi_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_CMD0, PH_CMD8, PH_PROBE, PH_POLL2, PH_POLL1, PH_POLLM,
    PH_CMD2, PH_CMD3, PH_CMD9, PH_CMD7, PH_CMD16, PH_ACMD6
  } phase_t;

  typedef struct packed {
    logic        issue;
    logic [5:0]  index;
    logic [31:0] arg;
    logic [1:0]  rk;
  } sdi_cmd_t;

  function automatic sdi_cmd_t make_cmd(logic [5:0] idx, logic [31:0] a, logic [1:0] k);
    sdi_cmd_t c;
    c.issue = 1'b1;
    c.index = idx;
    c.arg   = a;
    c.rk    = k;
    return c;
  endfunction

  phase_t                     phase_r, phase_nxt;
  logic                       pend_r, pend_nxt;
  logic [1:0]                 kind_r, kind_nxt;
  logic                       block_r, block_nxt;
  logic [15:0]                addr_r, addr_nxt;
  logic [ELAPSED_WIDTH-1:0]   elapsed_r, elapsed_nxt;
  logic                       wide_r, wide_nxt;
  logic [1:0]                 status_r, status_nxt;
  logic [TIMEOUT_WIDTH-1:0]   timeout_r;
  logic                       out_valid_r, out_valid_nxt;
  sdi_result_t                result_r, result_nxt;

  sdi_cmd_t                   cmd_o;
  logic                       crc_ok, ok, rdy, app_done;
  logic [ELAPSED_CMP_W-1:0]   elapsed_ext, timeout_ext;
  logic [31:0]                app_arg;

  assign take        = item_valid && (!out_valid_r || out_ch.ready);
  assign elapsed_ext = ELAPSED_CMP_W'(elapsed_r);
  assign timeout_ext = ELAPSED_CMP_W'(timeout_r);
  assign app_arg     = {addr_r, 16'h0000};

  // Decide the next state and the command for the held item
  always_comb begin
    phase_nxt   = phase_r;
    pend_nxt    = pend_r;
    kind_nxt    = kind_r;
    block_nxt   = block_r;
    addr_nxt    = addr_r;
    elapsed_nxt = elapsed_r;
    wide_nxt    = wide_r;
    status_nxt  = status_r;
    cmd_o       = '0;
    crc_ok      = 1'b0;
    ok          = 1'b0;
    rdy         = 1'b0;
    app_done    = 1'b0;
    case (item.cmd)
      KIND_START: begin
        kind_nxt  = CARD_UNKNOWN;
        block_nxt = 1'b0;
        addr_nxt  = '0;
        wide_nxt  = 1'b0;
        pend_nxt  = 1'b0;
        if (item.card_absent) begin
          status_nxt = INIT_NO_CARD;
          phase_nxt  = PH_IDLE;
        end else begin
          status_nxt = INIT_BUSY;
          phase_nxt  = PH_CMD0;
          cmd_o      = make_cmd(CMD_GO_IDLE, '0, REPLY_NONE);
        end
      end
      KIND_DONE: begin
        if (phase_r != PH_IDLE) begin
          crc_ok = phase_r inside {PH_PROBE, PH_POLL2, PH_POLL1, PH_POLLM};
          ok     = (item.cmd_status == CST_OK) || ((item.cmd_status == CST_CRC) && crc_ok);
          rdy    = ok && item.resp_word[31];
          // Check the CMD55 step, then send the ACMD body
          if (pend_r) begin
            pend_nxt = 1'b0;
            if ((item.cmd_status == CST_OK) && ((item.resp_word & R1_APP_CMD) != '0)) begin
              app_done = 1'b1;
              if (phase_r == PH_ACMD6) begin
                cmd_o = make_cmd(CMD_SET_BUS_W, ARG_BUS_4BIT, REPLY_SHORT);
              end else if (phase_r == PH_POLL2) begin
                cmd_o = make_cmd(CMD_SD_OP_COND, ARG_OP_COND_HCS, REPLY_SHORT);
              end else begin
                cmd_o = make_cmd(CMD_SD_OP_COND, ARG_OP_COND, REPLY_SHORT);
              end
            end else begin
              ok  = 1'b0;
              rdy = 1'b0;
            end
          end
          if (!app_done) begin
            case (phase_r)
              PH_CMD0: begin
                elapsed_nxt = '0;
                phase_nxt   = PH_CMD8;
                cmd_o       = make_cmd(CMD_SEND_IF_COND, ARG_IF_COND, REPLY_SHORT);
              end
              PH_CMD8: begin
                pend_nxt = 1'b1;
                cmd_o    = make_cmd(CMD_APP, app_arg, REPLY_SHORT);
                if (ok && (item.resp_word[11:0] == IF_COND_ECHO)) begin
                  phase_nxt = PH_POLL2;
                end else begin
                  phase_nxt = PH_PROBE;
                end
              end
              PH_POLL2: begin
                if (rdy) begin
                  kind_nxt  = CARD_SD2;
                  block_nxt = item.resp_word[30];
                  phase_nxt = PH_CMD2;
                  cmd_o     = make_cmd(CMD_ALL_SEND_CID, '0, REPLY_LONG);
                end else if (elapsed_ext >= timeout_ext) begin
                  status_nxt = INIT_FAILED;
                  phase_nxt  = PH_IDLE;
                  pend_nxt   = 1'b0;
                end else begin
                  pend_nxt = 1'b1;
                  cmd_o    = make_cmd(CMD_APP, app_arg, REPLY_SHORT);
                end
              end
              PH_PROBE: begin
                if (ok) begin
                  kind_nxt  = CARD_SD1;
                  pend_nxt  = 1'b1;
                  phase_nxt = PH_POLL1;
                  cmd_o     = make_cmd(CMD_APP, app_arg, REPLY_SHORT);
                end else begin
                  kind_nxt  = CARD_MMC;
                  phase_nxt = PH_POLLM;
                  cmd_o     = make_cmd(CMD_SEND_OP_COND, ARG_MMC_OP_COND, REPLY_SHORT);
                end
              end
              PH_POLL1, PH_POLLM: begin
                if (rdy) begin
                  phase_nxt = PH_CMD2;
                  cmd_o     = make_cmd(CMD_ALL_SEND_CID, '0, REPLY_LONG);
                end else if (elapsed_ext > timeout_ext) begin
                  status_nxt = INIT_FAILED;
                  phase_nxt  = PH_IDLE;
                  pend_nxt   = 1'b0;
                end else if (phase_r == PH_POLL1) begin
                  pend_nxt = 1'b1;
                  cmd_o    = make_cmd(CMD_APP, app_arg, REPLY_SHORT);
                end else begin
                  cmd_o = make_cmd(CMD_SEND_OP_COND, ARG_MMC_OP_COND, REPLY_SHORT);
                end
              end
              PH_CMD2: begin
                if (!ok) begin
                  status_nxt = INIT_FAILED;
                  phase_nxt  = PH_IDLE;
                end else begin
                  phase_nxt = PH_CMD3;
                  cmd_o     = make_cmd(CMD_SEND_RCA,
                                       (kind_r >= CARD_SD1) ? 32'h0 : ARG_MMC_RCA, REPLY_SHORT);
                end
              end
              PH_CMD3: begin
                if (!ok) begin
                  status_nxt = INIT_FAILED;
                  phase_nxt  = PH_IDLE;
                end else begin
                  addr_nxt  = (kind_r >= CARD_SD1) ? item.resp_word[31:16] : MMC_RCA;
                  phase_nxt = PH_CMD9;
                  cmd_o     = make_cmd(CMD_SEND_CSD, {addr_nxt, 16'h0000}, REPLY_LONG);
                end
              end
              PH_CMD9: begin
                if (!ok) begin
                  status_nxt = INIT_FAILED;
                  phase_nxt  = PH_IDLE;
                end else begin
                  phase_nxt = PH_CMD7;
                  cmd_o     = make_cmd(CMD_SELECT, app_arg, REPLY_SHORT);
                end
              end
              PH_CMD7, PH_CMD16: begin
                if (!ok || ((phase_r == PH_CMD16) &&
                            ((item.resp_word & R1_ERR_MASK) != '0))) begin
                  status_nxt = INIT_FAILED;
                  phase_nxt  = PH_IDLE;
                end else if ((phase_r == PH_CMD7) && !block_r) begin
                  phase_nxt = PH_CMD16;
                  cmd_o     = make_cmd(CMD_SET_BLOCKLEN, ARG_BLOCK_LEN, REPLY_SHORT);
                end else if (kind_r >= CARD_SD1) begin
                  pend_nxt  = 1'b1;
                  phase_nxt = PH_ACMD6;
                  cmd_o     = make_cmd(CMD_APP, app_arg, REPLY_SHORT);
                end else begin
                  status_nxt = INIT_READY;
                  phase_nxt  = PH_IDLE;
                end
              end
              PH_ACMD6: begin
                if (!ok || ((item.resp_word & R1_ERR_MASK) != '0)) begin
                  status_nxt = INIT_FAILED;
                  phase_nxt  = PH_IDLE;
                end else begin
                  wide_nxt   = 1'b1;
                  status_nxt = INIT_READY;
                  phase_nxt  = PH_IDLE;
                end
              end
              default: ;
            endcase
          end
        end
      end
      KIND_TICK: begin
        // Saturate the elapsed-time counter
        if (elapsed_r != '1) begin
          elapsed_nxt = elapsed_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Assemble the result from the command and the state after the item
  always_comb begin
    result_nxt.issue            = cmd_o.issue;
    result_nxt.cmd_index        = cmd_o.index;
    result_nxt.cmd_arg          = cmd_o.arg;
    result_nxt.resp_kind        = cmd_o.rk;
    result_nxt.init_status      = status_nxt;
    result_nxt.card_kind        = kind_nxt;
    result_nxt.block_addressing = block_nxt;
    result_nxt.card_address     = addr_nxt;
    result_nxt.wide_bus         = wide_nxt;
  end

  // Drop the result once taken, refill on every decided item
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold state, registered outputs and the timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pend_r      <= 1'b0;
      kind_r      <= CARD_UNKNOWN;
      block_r     <= 1'b0;
      addr_r      <= '0;
      elapsed_r   <= '0;
      wide_r      <= 1'b0;
      status_r    <= INIT_BUSY;
      timeout_r   <= TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        timeout_r <= cfg_ch.data;
      end
      if (take) begin
        phase_r   <= phase_nxt;
        pend_r    <= pend_nxt;
        kind_r    <= kind_nxt;
        block_r   <= block_nxt;
        addr_r    <= addr_nxt;
        elapsed_r <= elapsed_nxt;
        wide_r    <= wide_nxt;
        status_r  <= status_nxt;
      end
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (take) begin
      result_r <= result_nxt;
    end
  end

  assign cfg_ch.ready            = 1'b1;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.issue            = result_r.issue;
  assign out_ch.cmd_index        = result_r.cmd_index;
  assign out_ch.cmd_arg          = result_r.cmd_arg;
  assign out_ch.resp_kind        = result_r.resp_kind;
  assign out_ch.init_status      = result_r.init_status;
  assign out_ch.card_kind        = result_r.card_kind;
  assign out_ch.block_addressing = result_r.block_addressing;
  assign out_ch.card_address     = result_r.card_address;
  assign out_ch.wide_bus         = result_r.wide_bus;
endmodule

// File: rtl/sd_card_init_sequencer.sv
// Top level of the SD card start-up sequencer.
//
//   channel   dir  handshake               payload
//   in_ch     in   valid/ready             cmd, card_absent, cmd_status, resp_word
//   out_ch    out  valid/ready             issue, cmd_index, cmd_arg, resp_kind, status fields
//   cfg_ch    in   valid/ready (ready=1)   data = init_timeout_ms
//
// Each item goes from the input transfer into the input register, then
// through the state machine into the result register.
// Throughput is one item per cycle, one decided by the state machine, when not stalled.
// A stalled result holds the state machine and backs up into the input stage.
// Synchronous active-low reset returns to idle with a timeout of 1000 ms.
module sd_card_init_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  sdi_in_if.sink     in_ch,
  sdi_out_if.source  out_ch,
  sdi_cfg_if.sink    cfg_ch
);
  import sdi_pkg::*;

  logic      item_valid;
  logic      take;
  sdi_item_t item;

  // Register incoming items
  sdi_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Decide and register results
  sdi_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .cfg_ch     (cfg_ch),
    .out_ch     (out_ch)
  );
endmodule

// File: tb/sd_card_init_sequencer_tb.sv
// Self-checking testbench for the SD card start-up sequencer.
module sd_card_init_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdi_pkg::*;

  localparam int           CLK_HALF    = 4;
  localparam int           RESET_LEN   = 11;
  localparam int           CYCLE_LIMIT = 4_000_000;
  localparam int           DRAIN_LIMIT = 5000;
  localparam int           PRINT_CAP   = 40;
  // Codes the package leaves unnamed: an unused item kind and an unused status
  localparam logic [1:0]   KIND_UNUSED = 2'd3;
  localparam logic [1:0]   CST_UNUSED  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CMD0, ST_CMD8, ST_PROBE, ST_POLL2, ST_POLL1, ST_POLLM,
    ST_CMD2, ST_CMD3, ST_CMD9, ST_CMD7, ST_CMD16, ST_ACMD6
  } init_step_t;

  typedef enum logic [1:0] {RX_OPEN, RX_ALTERNATE, RX_RANDOM, RX_CHOKE} rx_mode_t;

  // Everything the sequencer remembers between items, plus its timeout register
  typedef struct packed {
    init_step_t               step;
    logic                     app_pending;
    logic [1:0]               kind;
    logic                     block_mode;
    logic [15:0]              rca;
    logic [ELAPSED_WIDTH-1:0] elapsed;
    logic                     wide;
    logic [1:0]               status;
    logic [TIMEOUT_WIDTH-1:0] timeout;
  } card_ctx_t;

  logic clk = 1'b0;
  logic rst_n;

  sdi_in_if  in_ch();
  sdi_out_if out_ch();
  sdi_cfg_if cfg_ch();

  sd_card_init_sequencer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  card_ctx_t   card_ctx;      // tracks transfers the block has taken
  card_ctx_t   plan_ctx;      // tracks items as they are queued
  sdi_item_t   card_events[$];
  sdi_result_t due_results[$];
  sdi_item_t   next_event;
  sdi_item_t   seen_event;
  sdi_result_t want;
  logic        event_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_left = 0;
  int          cycles = 0;
  int          mismatches = 0;

  function automatic card_ctx_t reset_ctx();
    card_ctx_t c;
    c = '0;
    c.step = ST_IDLE;
    c.timeout = TIMEOUT_RESET;
    return c;
  endfunction

  function automatic void issue_cmd(inout sdi_result_t r, inout card_ctx_t c,
                                    input init_step_t nxt, input logic [5:0] idx,
                                    input logic [31:0] arg, input logic [1:0] rk);
    c.step = nxt;
    r.issue = 1'b1;
    r.cmd_index = idx;
    r.cmd_arg = arg;
    r.resp_kind = rk;
  endfunction

  // CMD55 ahead of an application command
  function automatic void issue_app(inout sdi_result_t r, inout card_ctx_t c,
                                    input init_step_t nxt);
    c.app_pending = 1'b1;
    issue_cmd(r, c, nxt, CMD_APP, {c.rca, 16'h0000}, REPLY_SHORT);
  endfunction

  function automatic void abort_init(inout card_ctx_t c);
    c.status = INIT_FAILED;
    c.step = ST_IDLE;
    c.app_pending = 1'b0;
  endfunction

  // SD cards still select the wide bus; MMC is done here
  function automatic void finish_setup(inout sdi_result_t r, inout card_ctx_t c);
    if (c.kind >= CARD_SD1) begin
      issue_app(r, c, ST_ACMD6);
    end else begin
      c.status = INIT_READY;
      c.step = ST_IDLE;
    end
  endfunction

  // Advance the sequencer by one item and return the result it produces
  function automatic sdi_result_t card_step(inout card_ctx_t c, input sdi_item_t ev);
    sdi_result_t r;
    logic        crc_ok;
    logic        ok;
    logic        rdy;
    logic        app_sent;
    r = '0;
    app_sent = 1'b0;
    case (ev.cmd)
      KIND_START: begin
        c.kind = CARD_UNKNOWN;
        c.block_mode = 1'b0;
        c.rca = '0;
        c.wide = 1'b0;
        c.app_pending = 1'b0;
        if (ev.card_absent) begin
          c.status = INIT_NO_CARD;
          c.step = ST_IDLE;
        end else begin
          c.status = INIT_BUSY;
          issue_cmd(r, c, ST_CMD0, CMD_GO_IDLE, '0, REPLY_NONE);
        end
      end
      KIND_DONE: if (c.step != ST_IDLE) begin
        // CRC errors are tolerated on the op-cond commands
        crc_ok = (c.step == ST_PROBE) || (c.step == ST_POLL2) ||
                 (c.step == ST_POLL1) || (c.step == ST_POLLM);
        ok = (ev.cmd_status == CST_OK) || (ev.cmd_status == CST_CRC && crc_ok);
        rdy = ok && ev.resp_word[31];
        if (c.app_pending) begin
          c.app_pending = 1'b0;
          if (ev.cmd_status == CST_OK && (ev.resp_word & R1_APP_CMD) != 0) begin
            app_sent = 1'b1;
            if (c.step == ST_ACMD6)
              issue_cmd(r, c, c.step, CMD_SET_BUS_W, ARG_BUS_4BIT, REPLY_SHORT);
            else if (c.step == ST_POLL2)
              issue_cmd(r, c, c.step, CMD_SD_OP_COND, ARG_OP_COND_HCS, REPLY_SHORT);
            else
              issue_cmd(r, c, c.step, CMD_SD_OP_COND, ARG_OP_COND, REPLY_SHORT);
          end else begin
            ok = 1'b0;
            rdy = 1'b0;
          end
        end
        if (!app_sent) begin
          case (c.step)
            ST_CMD0: begin
              c.elapsed = '0;
              issue_cmd(r, c, ST_CMD8, CMD_SEND_IF_COND, ARG_IF_COND, REPLY_SHORT);
            end
            ST_CMD8: begin
              if (ok && ev.resp_word[11:0] == IF_COND_ECHO) issue_app(r, c, ST_POLL2);
              else issue_app(r, c, ST_PROBE);
            end
            ST_POLL2: begin
              if (rdy) begin
                c.kind = CARD_SD2;
                c.block_mode = ev.resp_word[30];
                issue_cmd(r, c, ST_CMD2, CMD_ALL_SEND_CID, '0, REPLY_LONG);
              end else if (c.elapsed >= c.timeout) begin
                abort_init(c);
              end else begin
                issue_app(r, c, ST_POLL2);
              end
            end
            ST_PROBE: begin
              if (ok) begin
                c.kind = CARD_SD1;
                issue_app(r, c, ST_POLL1);
              end else begin
                c.kind = CARD_MMC;
                issue_cmd(r, c, ST_POLLM, CMD_SEND_OP_COND, ARG_MMC_OP_COND, REPLY_SHORT);
              end
            end
            ST_POLL1, ST_POLLM: begin
              if (rdy)
                issue_cmd(r, c, ST_CMD2, CMD_ALL_SEND_CID, '0, REPLY_LONG);
              else if (c.elapsed > c.timeout)
                abort_init(c);
              else if (c.step == ST_POLL1)
                issue_app(r, c, ST_POLL1);
              else
                issue_cmd(r, c, ST_POLLM, CMD_SEND_OP_COND, ARG_MMC_OP_COND, REPLY_SHORT);
            end
            ST_CMD2: begin
              if (!ok) abort_init(c);
              else issue_cmd(r, c, ST_CMD3, CMD_SEND_RCA,
                             (c.kind >= CARD_SD1) ? 32'h0 : ARG_MMC_RCA, REPLY_SHORT);
            end
            ST_CMD3: begin
              if (!ok) begin
                abort_init(c);
              end else begin
                c.rca = (c.kind >= CARD_SD1) ? ev.resp_word[31:16] : MMC_RCA;
                issue_cmd(r, c, ST_CMD9, CMD_SEND_CSD, {c.rca, 16'h0000}, REPLY_LONG);
              end
            end
            ST_CMD9: begin
              if (!ok) abort_init(c);
              else issue_cmd(r, c, ST_CMD7, CMD_SELECT, {c.rca, 16'h0000}, REPLY_SHORT);
            end
            ST_CMD7: begin
              if (!ok) abort_init(c);
              else if (!c.block_mode)
                issue_cmd(r, c, ST_CMD16, CMD_SET_BLOCKLEN, ARG_BLOCK_LEN, REPLY_SHORT);
              else finish_setup(r, c);
            end
            ST_CMD16: begin
              if (!ok || (ev.resp_word & R1_ERR_MASK) != 0) abort_init(c);
              else finish_setup(r, c);
            end
            ST_ACMD6: begin
              if (!ok || (ev.resp_word & R1_ERR_MASK) != 0) begin
                abort_init(c);
              end else begin
                c.wide = 1'b1;
                c.status = INIT_READY;
                c.step = ST_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
      KIND_TICK: if (c.elapsed != '1) c.elapsed = c.elapsed + 1'b1;
      default: ;
    endcase
    r.init_status = c.status;
    r.card_kind = c.kind;
    r.block_addressing = c.block_mode;
    r.card_address = c.rca;
    r.wide_bus = c.wide;
    return r;
  endfunction

  // Pick a plausible card reply for the current step, with some noise mixed in
  function automatic sdi_item_t pick_item(input card_ctx_t c);
    sdi_item_t ev;
    int        roll;
    logic      polling;
    roll = $urandom_range(99);
    polling = (c.step == ST_POLL2) || (c.step == ST_POLL1) || (c.step == ST_POLLM);
    ev.cmd = KIND_DONE;
    ev.card_absent = 1'($urandom_range(1));
    ev.cmd_status = CST_OK;
    ev.resp_word = $urandom;
    if (roll < 5) begin
      ev.cmd = 2'($urandom_range(3));
      ev.cmd_status = 2'($urandom_range(3));
    end else if (c.step == ST_IDLE) begin
      ev.cmd = KIND_START;
      ev.card_absent = ($urandom_range(9) == 0);
    end else if (roll < 6) begin
      ev.cmd = KIND_START;
      ev.card_absent = 1'b0;
    end else if (roll < (polling ? 40 : 10)) begin
      ev.cmd = KIND_TICK;
    end else if (c.app_pending) begin
      if ($urandom_range(9) == 0) ev.cmd_status = 2'($urandom_range(2));
      else ev.resp_word[5] = 1'b1;
    end else begin
      case (c.step)
        ST_CMD8: begin
          if ($urandom_range(4) < 3) ev.resp_word[11:0] = IF_COND_ECHO;
          else ev.cmd_status = 2'($urandom_range(2));
        end
        ST_PROBE: ev.cmd_status = 2'($urandom_range(2));
        ST_POLL2, ST_POLL1, ST_POLLM: begin
          if ($urandom_range(4) == 0) ev.cmd_status = CST_TIMEOUT;
          else ev.cmd_status = $urandom_range(1) ? CST_CRC : CST_OK;
          ev.resp_word[31] = ($urandom_range(3) == 0);
        end
        ST_CMD16, ST_ACMD6: begin
          if ($urandom_range(6) != 0) ev.resp_word = ev.resp_word & ~R1_ERR_MASK;
          if ($urandom_range(9) == 0) ev.cmd_status = 2'($urandom_range(2));
        end
        default: if ($urandom_range(9) == 0) ev.cmd_status = 2'($urandom_range(2));
      endcase
    end
    return ev;
  endfunction

  task automatic post_event(input logic [1:0] kind, input logic absent,
                            input logic [1:0] st, input logic [31:0] resp);
    sdi_item_t   ev;
    sdi_result_t plan_res;
    ev.cmd = kind;
    ev.card_absent = absent;
    ev.cmd_status = st;
    ev.resp_word = resp;
    card_events.push_back(ev);
    plan_res = card_step(plan_ctx, ev);
  endtask

  task automatic plan_random(input int count);
    sdi_item_t ev;
    repeat (count) begin
      ev = pick_item(plan_ctx);
      post_event(ev.cmd, ev.card_absent, ev.cmd_status, ev.resp_word);
    end
  endtask

  task automatic wait_drained();
    while (card_events.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  // Write the timeout only once nothing is in flight
  task automatic set_timeout(input logic [15:0] ms);
    wait_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= ms;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    card_ctx.timeout = ms;
    plan_ctx.timeout = ms;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what,
               exp_val, got_val);
  endtask

  // Drive the next queued item at the falling edge, in bursts with gaps
  always @(negedge clk) begin : card_event_driver
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || event_taken) begin
      event_taken = 1'b0;
      if (gap_left != 0 || card_events.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        next_event = card_events.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= next_event.cmd;
        in_ch.card_absent <= next_event.card_absent;
        in_ch.cmd_status <= next_event.cmd_status;
        in_ch.resp_word <= next_event.resp_word;
        if (burst_left != 0) begin
          burst_left--;
        end else if ($urandom_range(4) == 0) begin
          burst_left = $urandom_range(300, 100);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(24);
          gap_left = $urandom_range(7);
        end
      end
    end
  end

  // Predict the result of each input transfer
  always @(posedge clk) begin : card_event_capture
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen_event.cmd = in_ch.cmd;
      seen_event.card_absent = in_ch.card_absent;
      seen_event.cmd_status = in_ch.cmd_status;
      seen_event.resp_word = in_ch.resp_word;
      due_results.push_back(card_step(card_ctx, seen_event));
      event_taken = 1'b1;
    end
  end

  // Stall the result channel in randomly chosen modes, each held for a random run
  always @(negedge clk) begin : result_backpressure
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(3));
      rx_left = $urandom_range(96, 16);
    end
    rx_left--;
    if (!rst_n) out_ch.ready <= 1'b0;
    else begin
      case (rx_mode)
        RX_OPEN:      out_ch.ready <= 1'b1;
        RX_ALTERNATE: out_ch.ready <= cycles[0];
        RX_RANDOM:    out_ch.ready <= ($urandom_range(9) > 2);
        default:      out_ch.ready <= ($urandom_range(7) == 0);
      endcase
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_monitor
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        note_mismatch("result with nothing predicted", 32'h0, {26'h0, out_ch.cmd_index});
      end else begin
        want = due_results.pop_front();
        if (out_ch.issue !== want.issue)
          note_mismatch("issue", 32'(want.issue), 32'(out_ch.issue));
        if (out_ch.cmd_index !== want.cmd_index)
          note_mismatch("cmd_index", 32'(want.cmd_index), 32'(out_ch.cmd_index));
        if (out_ch.cmd_arg !== want.cmd_arg)
          note_mismatch("cmd_arg", want.cmd_arg, out_ch.cmd_arg);
        if (out_ch.resp_kind !== want.resp_kind)
          note_mismatch("resp_kind", 32'(want.resp_kind), 32'(out_ch.resp_kind));
        if (out_ch.init_status !== want.init_status)
          note_mismatch("init_status", 32'(want.init_status), 32'(out_ch.init_status));
        if (out_ch.card_kind !== want.card_kind)
          note_mismatch("card_kind", 32'(want.card_kind), 32'(out_ch.card_kind));
        if (out_ch.block_addressing !== want.block_addressing)
          note_mismatch("block_addressing", 32'(want.block_addressing),
                        32'(out_ch.block_addressing));
        if (out_ch.card_address !== want.card_address)
          note_mismatch("card_address", 32'(want.card_address), 32'(out_ch.card_address));
        if (out_ch.wide_bus !== want.wide_bus)
          note_mismatch("wide_bus", 32'(want.wide_bus), 32'(out_ch.wide_bus));
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : test_sequence
    int waited;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = KIND_START;
    in_ch.card_absent = 1'b0;
    in_ch.cmd_status = CST_OK;
    in_ch.resp_word = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = TIMEOUT_RESET;
    card_ctx = reset_ctx();
    plan_ctx = reset_ctx();
    repeat (RESET_LEN) @(negedge clk);
    rst_n <= 1'b1;

    // Idle handling: completion ignored, tick, unused kind, no card
    post_event(KIND_DONE, 1'b1, CST_CRC, 32'hFFFF_FFFF);
    post_event(KIND_TICK, 1'b0, CST_OK, 32'h0);
    post_event(KIND_UNUSED, 1'b1, CST_UNUSED, 32'hFFFF_FFFF);
    post_event(KIND_START, 1'b1, CST_OK, 32'h0);
    // High-capacity SD card, reset timeout, all the way to the wide bus
    post_event(KIND_START, 1'b0, CST_OK, 32'h0);
    post_event(KIND_DONE, 1'b0, CST_TIMEOUT, 32'h0);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h0000_01AA);
    post_event(KIND_DONE, 1'b0, CST_OK, R1_APP_CMD);
    post_event(KIND_TICK, 1'b0, CST_OK, 32'h0);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h0000_0000);
    post_event(KIND_DONE, 1'b0, CST_OK, R1_APP_CMD);
    post_event(KIND_DONE, 1'b0, CST_CRC, 32'hC000_0000);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h0);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'hFFFF_0000);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h0);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h0);
    post_event(KIND_DONE, 1'b0, CST_OK, R1_APP_CMD);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h0000_0900);
    // Restart: CRC on CMD8, missing APP_CMD bit, so the card falls to MMC
    post_event(KIND_START, 1'b0, CST_OK, 32'h0);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h0);
    post_event(KIND_DONE, 1'b0, CST_CRC, 32'h0000_01AA);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h0000_0000);
    post_event(KIND_DONE, 1'b0, CST_UNUSED, 32'hFFFF_FFFF);

    set_timeout(16'd1);
    plan_random(300);
    set_timeout(16'd5);
    plan_random(300);
    set_timeout(16'd40);
    plan_random(300);

    // Largest timeout: MMC poll keeps going after a run of ticks
    set_timeout(16'hFFFF);
    post_event(KIND_START, 1'b0, CST_OK, 32'h0);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h0);
    post_event(KIND_DONE, 1'b0, CST_TIMEOUT, 32'h0);
    post_event(KIND_DONE, 1'b0, CST_OK, R1_APP_CMD);
    post_event(KIND_DONE, 1'b0, CST_TIMEOUT, 32'h0);
    repeat (40) post_event(KIND_TICK, 1'b0, CST_OK, 32'h0);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h0000_0000);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h8000_0000);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h0);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h1234_0000);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h0);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h0);
    post_event(KIND_DONE, 1'b0, CST_OK, 32'h0008_0000);
    plan_random(100);

    set_timeout(16'd2);
    plan_random(250);

    // Let the last items go in, then wait out the remaining results
    while (card_events.size() != 0 || in_ch.valid) @(posedge clk);
    waited = 0;
    while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (due_results.size() != 0)
      note_mismatch("results never delivered", 32'(due_results.size()), 32'h0);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
